// File: design/pc_sample_histogram_defines.svh
// Assertion shorthands shared by the histogram RTL.
`ifndef PC_SAMPLE_HISTOGRAM_DEFINES_SVH
`define PC_SAMPLE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pch_pkg.sv
package pch_pkg;

	localparam int PC_W    = 32;
	localparam int CNT_W   = 16;
	localparam int SEL_W   = 12;
	localparam int SCALE_W = 17;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// half the PC offset times scale, then drop the 16 fraction bits
	localparam int HALF_W  = PC_W - 1;
	localparam int PROD_W  = HALF_W + SCALE_W;
	localparam int FRAC_W  = 16;
	localparam int IDX_W   = PROD_W - FRAC_W;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE  = 2'd0,
		REG_LOW_PC  = 2'd1,
		REG_HIGH_PC = 2'd2,
		REG_SCALE   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL,
		ST_RD,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [PC_W-1:0] pc;
		logic [SEL_W-1:0] bin_select;
	} item_t;

	typedef struct packed {
		logic             hit;
		logic             out_of_store;
		logic [SEL_W-1:0] bin_index;
		logic [CNT_W-1:0] bin_count;
	} result_t;

endpackage

// File: design/pc_sample_histogram.sv
// PC sampling histogram.
// Command side: drive item and raise start; the word is taken at the rising edge
// where start is high and busy is low. item.op selects sample, read bin or clear bin.
// Result side: done is high for exactly one cycle with result valid; the receiver
// cannot stall, so the word must be taken in that cycle.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (enable, low_pc,
// high_pc, scale) at any edge; change it only while no command is in flight.
// Flow: a new word is accepted no earlier than the write-back step of the previous
// one, as the single-port histogram RAM takes each word through range check,
// scale multiply, RAM read, then modify and write back.
// Reset: arst_n clears control and configuration (scale resets to one), then a
// clearing pass writes zero to every bin, one bin per cycle. busy stays high
// during the pass; configuration writes are still taken.
`include "pc_sample_histogram_defines.svh"

module pc_sample_histogram
	import pch_pkg::*;
#(
	parameter int BINS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam logic [AW-1:0]    LAST_BIN = AW'(BINS - 1);
	localparam logic [IDX_W-1:0] BINS_IDX = IDX_W'(BINS);

	state_t state_q, state_d;

	logic               enable_q;
	logic [PC_W-1:0]    low_pc_q;
	logic [PC_W-1:0]    high_pc_q;
	logic [SCALE_W-1:0] scale_q;

	logic               accept;
	logic [1:0]         op_q;
	logic [SEL_W-1:0]   sel_q;
	logic               sample_ok_q;
	logic [HALF_W-1:0]  half_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AW-1:0]      addr_q;
	logic               access_q;
	logic               oos_q;
	logic [SEL_W-1:0]   idx_out_q;
	logic [CNT_W-1:0]   rd_data_q;
	logic [AW-1:0]      clr_q;
	logic               done_q;
	result_t            result_q;

	logic [CNT_W-1:0]   hist_mem [BINS];

	logic               in_range;
	logic [PC_W-1:0]    pc_diff;
	logic [SCALE_W-1:0] scale_eff;
	logic [IDX_W-1:0]   idx;
	logic               rd_access;
	logic               rd_oos;
	logic [SEL_W-1:0]   rd_idx_out;
	logic [AW-1:0]      rd_addr;
	logic               wr_upd;
	logic [CNT_W-1:0]   new_cnt;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CNT_W-1:0]   mem_wdata;

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		accept  = 1'b0;
		case (state_q)
			ST_CLR: begin
				if (clr_q == LAST_BIN) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE, ST_UPD: begin
				busy   = 1'b0;
				accept = start;
				state_d = start ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_UPD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			low_pc_q  <= '0;
			high_pc_q <= '0;
			scale_q   <= SCALE_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_wdata[0];
				REG_LOW_PC:  low_pc_q  <= cfg_wdata[PC_W-1:0];
				REG_HIGH_PC: high_pc_q <= cfg_wdata[PC_W-1:0];
				REG_SCALE:   scale_q   <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// accept: range check and offset
	assign pc_diff  = item.pc - low_pc_q;
	assign in_range = enable_q && (scale_q != '0) &&
		(item.pc >= low_pc_q) && (item.pc < high_pc_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= item.op;
			sel_q       <= item.bin_select;
			sample_ok_q <= in_range;
			half_q      <= pc_diff[PC_W-1:1];
		end
	end

	// scale multiply, saturated at one
	assign scale_eff = (scale_q > SCALE_ONE) ? SCALE_ONE : scale_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= half_q * scale_eff;
		end
	end

	// read stage: resolve the bin and issue the RAM read
	assign idx = prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		rd_access  = 1'b0;
		rd_oos     = 1'b0;
		rd_idx_out = '0;
		rd_addr    = '0;
		case (op_q)
			OP_SAMPLE: begin
				if (sample_ok_q) begin
					if (idx >= BINS_IDX) begin
						rd_oos = 1'b1;
					end else begin
						rd_access  = 1'b1;
						rd_addr    = AW'(idx);
						rd_idx_out = idx[SEL_W-1:0];
					end
				end
			end
			OP_READ, OP_CLEAR: begin
				rd_idx_out = sel_q;
				if (IDX_W'(sel_q) >= BINS_IDX) begin
					rd_oos = 1'b1;
				end else begin
					rd_access = 1'b1;
					rd_addr   = AW'(sel_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			addr_q    <= rd_addr;
			access_q  <= rd_access;
			oos_q     <= rd_oos;
			idx_out_q <= rd_idx_out;
		end
	end

	// one access at a time: the write in UPD lands before the next read in RD
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rd_data_q <= hist_mem[rd_addr];
		end
	end

	// modify and write back, or sweep zeros after reset
	assign wr_upd  = (state_q == ST_UPD) && access_q &&
		((op_q == OP_SAMPLE) || (op_q == OP_CLEAR));
	assign new_cnt = (op_q == OP_SAMPLE) ? rd_data_q + CNT_W'(1) : '0;

	assign mem_we    = (state_q == ST_CLR) || wr_upd;
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == ST_CLR) ? '0 : new_cnt;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPD);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			result_q.hit          <= access_q && (op_q == OP_SAMPLE);
			result_q.out_of_store <= oos_q;
			result_q.bin_index    <= idx_out_q;
			if (!access_q) begin
				result_q.bin_count <= '0;
			end else if (op_q == OP_READ) begin
				result_q.bin_count <= rd_data_q;
			end else begin
				result_q.bin_count <= new_cnt;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PCH_ASSERT_NOW(a_done_after_upd, done, $past(state_q == ST_UPD), "done without update")
	`PCH_ASSERT_NOW(a_hit_oos_excl, done, !(result.hit && result.out_of_store), "hit and oos")
	`PCH_ASSERT_NOW(a_hit_is_sample, done && result.hit, $past(op_q == OP_SAMPLE), "hit on non-sample")
	`PCH_ASSERT_NEXT(a_accept_to_mul, start && !busy, state_q == ST_MUL, "accept lost")

endmodule
